// ===== rtl/oal_pkg.sv =====
// Shared constants, codes and types of the ordered array list.
package oal_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   // fixed field widths of the channels
   localparam int MODE_W    = 2;
   localparam int POS_W     = 5;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 4;
   localparam int COUNT_W   = 5;
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT,
      MODE_DELETE,
      MODE_FIND,
      MODE_NOP
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_POSITION,
      STAT_MISS
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_COMPARE,
      CTL_EXEC
   } ctl_state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type            op;
      logic [IDX_W-1:0]       pivot;
      logic [WORD_BITS-1:0]   key;
      logic [CNT_W-1:0]       count;
   } cell_cmd_type;

endpackage

// ===== rtl/oal_if.sv =====
// Channel interfaces of the ordered array list: request, response and register write.
interface oal_req_if import oal_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, mode, position, value, input ready);
   modport sink   (input valid, mode, position, value, output ready);
endinterface

interface oal_rsp_if import oal_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  index;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, status, index, count, input ready);
   modport sink   (input valid, status, index, count, output ready);
endinterface

interface oal_csr_if import oal_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/oal_cell.sv =====
// One list entry: holds a word, compares it with the key and shifts toward a neighbor.
module oal_cell import oal_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     cell_idx,
   input  cell_cmd_type         cmd,
   input  logic [WORD_BITS-1:0] left_data,
   input  logic [WORD_BITS-1:0] right_data,
   output logic [WORD_BITS-1:0] data,
   output logic                 match
);

   logic [WORD_BITS-1:0] data_ff, data_in;
   logic                 match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = (data_ff == cmd.key) && (CNT_W'(cell_idx) < cmd.count);
      case (cmd.op)
         CELL_INSERT: begin
            if (cell_idx > cmd.pivot) begin
               data_in = left_data;
            end else if (cell_idx == cmd.pivot) begin
               data_in = cmd.key;
            end
         end
         CELL_REMOVE: begin
            if (cell_idx >= cmd.pivot) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// ===== rtl/oal_ctrl.sv =====
// Sequencer: takes a request, picks the first matching cell, drives the shift and the response.
module oal_ctrl import oal_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   oal_req_if.sink          req_chan,
   oal_rsp_if.source        rsp_chan,
   oal_csr_if.sink          csr_chan,
   input  logic [DEPTH-1:0] match,
   output cell_cmd_type     cmd
);

   ctl_state_type        state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [WORD_BITS-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 hit;
   logic [IDX_W-1:0]     first;
   logic [31:0]          eff_cap;
   logic                 full;
   logic                 beyond;
   logic                 rsp_free;
   cell_op_type          op;
   logic [IDX_W-1:0]     pivot;

   // lowest matching cell wins
   always_comb begin
      hit   = 1'b0;
      first = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit   = 1'b1;
            first = IDX_W'(i);
         end
      end
   end

   assign eff_cap  = (32'(cap_ff) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cap_ff);
   assign full     = 32'(count_ff) >= eff_cap;
   assign beyond   = 32'(pos_ff) > 32'(count_ff);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      index_in     = index_ff;
      rsp_count_in = rsp_count_ff;
      op           = CELL_HOLD;
      pivot        = '0;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_chan.valid) begin
               mode_in  = req_chan.mode;
               pos_in   = req_chan.position;
               key_in   = WORD_BITS'($unsigned(req_chan.value));
               state_in = CTL_COMPARE;
            end
         end
         CTL_COMPARE: begin
            // cells register their match flags against the held key
            state_in = CTL_EXEC;
         end
         CTL_EXEC: begin
            if (rsp_free) begin
               state_in     = CTL_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               index_in     = '0;
               unique case (mode_type'(mode_ff))
                  MODE_INSERT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else if (beyond) begin
                        status_in = STAT_POSITION;
                     end else begin
                        op       = CELL_INSERT;
                        pivot    = IDX_W'(pos_ff);
                        count_in = count_ff + CNT_W'(1);
                        index_in = INDEX_W'(pos_ff);
                     end
                  end
                  MODE_DELETE: begin
                     if (hit) begin
                        op       = CELL_REMOVE;
                        pivot    = first;
                        count_in = count_ff - CNT_W'(1);
                        index_in = INDEX_W'(first);
                     end else begin
                        status_in = STAT_MISS;
                     end
                  end
                  MODE_FIND: begin
                     if (hit) begin
                        index_in = INDEX_W'(first);
                     end else begin
                        status_in = STAT_MISS;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   assign cap_in = csr_chan.valid ? csr_chan.data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      index_ff     <= index_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign cmd.op    = op;
   assign cmd.pivot = pivot;
   assign cmd.key   = key_ff;
   assign cmd.count = count_ff;

   assign req_chan.ready  = (state_ff == CTL_IDLE);
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.index  = index_ff;
   assign rsp_chan.count  = rsp_count_ff;

endmodule

// ===== rtl/ordered_array_list.sv =====
// Top level of the ordered array list: sequencer plus a chain of entry cells.
//
// Keeps up to DEPTH signed words in order with a count. A request on req_chan
// carries mode (insert at position, delete first match, find first match or
// no-op), position and value; each request gives one response on rsp_chan with
// status, index and the count after the request.
// csr_chan writes capacity_limit (always ready); write it only while idle.
// Steps of a request: accept while idle; compare, in which every cell
// registers its compare against the key; execute, which picks the first match,
// shifts the cells left or right by one and registers the response.
// req_chan.ready is high only while no request is in work, so a new request
// is taken only once the previous one has left the execute step.
// The response sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, the next request holds in its last cycle
// until the response register frees up.
// Reset clears the count and sets the capacity to 16; entry contents are not
// cleared and are never read before being written.
module ordered_array_list import oal_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   oal_req_if.sink   req_chan,
   oal_rsp_if.source rsp_chan,
   oal_csr_if.sink   csr_chan
);

   cell_cmd_type         cmd;
   logic [DEPTH-1:0]     match;
   logic [WORD_BITS-1:0] data [DEPTH];

   oal_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .match    (match),
      .cmd      (cmd)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] left_data;
      logic [WORD_BITS-1:0] right_data;

      // ends of the chain: first cell never takes from the left,
      // last cell keeps its own word on a remove
      if (g == 0) begin : g_head
         assign left_data = cmd.key;
      end else begin : g_body
         assign left_data = data[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_data = data[g];
      end else begin : g_mid
         assign right_data = data[g+1];
      end

      oal_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(g)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (data[g]),
         .match      (match[g])
      );
   end

endmodule

// ===== rtl/oal_checker.sv =====
// Port-level checks of the ordered array list, bound to the top level.
module oal_checker import oal_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [INDEX_W-1:0]  rsp_index,
   input logic [COUNT_W-1:0]  rsp_count
);

   // a pending response is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_count) <= 32'(DEPTH))
      else $error("count above list depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_index == '0)
      else $error("failed request reports a nonzero index");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_index  (rsp_chan.index),
   .rsp_count  (rsp_chan.count)
);

// ===== bench/tb.sv =====
// Self-checking bench for ordered_array_list: directed and random list traffic.
module tb import oal_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PRINT_LIMIT    = 60;
   localparam int PHASES         = 8;

   typedef struct {
      status_type            status;
      logic [INDEX_W-1:0]    index;
      logic [COUNT_W-1:0]    count;
   } list_answer_type;

   // Shadow copy of the list plus the queue of answers still owed by the block.
   class list_scoreboard;
      logic [WORD_BITS-1:0] held [DEPTH];
      int                   held_count;
      logic [CAP_W-1:0]     capacity;
      list_answer_type      awaited [$];
      int unsigned          failures;
      int unsigned          answered;
      int unsigned          noted;
      int unsigned          status_seen [4];
      int unsigned          mode_seen [4];

      function new();
         held_count = 0;
         capacity   = CAP_W'(CAP_RESET);
         failures   = 0;
         answered   = 0;
         noted      = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         foreach (mode_seen[i]) mode_seen[i] = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] v);
         capacity = v;
      endfunction

      function int first_hit(logic [WORD_BITS-1:0] v);
         for (int i = 0; i < held_count; i++)
            if (held[i] == v) return i;
         return -1;
      endfunction

      function logic [WORD_BITS-1:0] pick_held();
         return held[$urandom_range(0, held_count - 1)];
      endfunction

      function void note_request(mode_type m, logic [POS_W-1:0] pos,
                                 logic [VALUE_W-1:0] v);
         int              room;
         int              hit;
         list_answer_type ans;
         // register values above DEPTH saturate
         room       = (capacity > DEPTH) ? DEPTH : int'(capacity);
         ans.status = STAT_OK;
         ans.index  = '0;
         case (m)
            MODE_INSERT: begin
               if (held_count >= room) begin
                  ans.status = STAT_FULL;
               end else if (int'(pos) > held_count) begin
                  ans.status = STAT_POSITION;
               end else begin
                  for (int i = held_count; i > int'(pos); i--) held[i] = held[i-1];
                  held[pos]  = v;
                  held_count = held_count + 1;
                  ans.index  = pos[INDEX_W-1:0];
               end
            end
            MODE_DELETE: begin
               hit = first_hit(v);
               if (hit < 0) begin
                  ans.status = STAT_MISS;
               end else begin
                  for (int i = hit; i + 1 < held_count; i++) held[i] = held[i+1];
                  held_count = held_count - 1;
                  ans.index  = hit[INDEX_W-1:0];
               end
            end
            MODE_FIND: begin
               hit = first_hit(v);
               if (hit < 0) ans.status = STAT_MISS;
               else ans.index = hit[INDEX_W-1:0];
            end
            default: begin
            end
         endcase
         ans.count = held_count[COUNT_W-1:0];
         awaited.push_back(ans);
         status_seen[ans.status]++;
         mode_seen[m]++;
         noted++;
      endfunction

      task report(string what);
         failures++;
         if (failures <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
      endtask

      task check_response(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] ix,
                          logic [COUNT_W-1:0] cnt);
         list_answer_type want;
         answered++;
         if (awaited.size() == 0) begin
            report($sformatf("response %0d unexpected: status %0d index %0d count %0d",
                             answered, st, ix, cnt));
            return;
         end
         want = awaited.pop_front();
         if (st !== want.status)
            report($sformatf("response %0d status %0d, want %s", answered, st,
                             want.status.name()));
         if (ix !== want.index)
            report($sformatf("response %0d index %0d, want %0d", answered, ix, want.index));
         if (cnt !== want.count)
            report($sformatf("response %0d count %0d, want %0d", answered, cnt, want.count));
      endtask
   endclass

   logic clock;
   logic reset;

   oal_req_if req_bus ();
   oal_rsp_if rsp_bus ();
   oal_csr_if csr_bus ();

   ordered_array_list dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   list_scoreboard       book;
   bit                   sender_calm = 1'b0;
   int                   stalled = 0;
   int                   sink_cycles = 0;
   int                   cap_writes = 0;
   logic [WORD_BITS-1:0] value_pool [8];
   int                   phase_cap [PHASES] = '{1, 31, 0, 8, 17, 5, 16, 12};
   int                   phase_len [PHASES] = '{120, 200, 40, 180, 200, 120, 200, 140};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_request(mode_type m, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] v);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= m;
      req_bus.position <= pos;
      req_bus.value    <= v;
      do @(posedge clock); while (!req_bus.ready);
      book.note_request(m, pos, v);
      gap = (sender_calm || $urandom_range(99) >= 35) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (book.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] v);
      req_bus.valid <= 1'b0;
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      book.set_capacity(v);
      csr_bus.valid <= 1'b0;
      cap_writes++;
   endtask

   task automatic refresh_pool();
      foreach (value_pool[i]) value_pool[i] = $urandom();
   endtask

   function automatic logic [WORD_BITS-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return value_pool[$urandom_range(0, 7)];
      if (roll < 58) return 32'h8000_0000;
      if (roll < 61) return 32'h7fff_ffff;
      if (roll < 64) return 32'hffff_ffff;
      if (roll < 66) return 32'h0;
      return $urandom();
   endfunction

   // Mostly positions within the list, so inserts land; some deliberately past it.
   task automatic random_item(int grow_pct);
      int                 roll;
      mode_type           m;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] v;
      roll = $urandom_range(99);
      if (roll < 3) m = MODE_NOP;
      else if (roll < 3 + grow_pct) m = MODE_INSERT;
      else if ($urandom_range(1)) m = MODE_DELETE;
      else m = MODE_FIND;
      roll = $urandom_range(99);
      if (roll < 85) pos = POS_W'($urandom_range(0, book.held_count));
      else if (roll < 93) pos = POS_W'(book.held_count + 1);
      else pos = POS_W'($urandom_range(0, 31));
      if (m != MODE_INSERT && book.held_count > 0 && $urandom_range(99) < 60)
         v = book.pick_held();
      else
         v = pick_value();
      send_request(m, pos, v);
   endtask

   task automatic directed_items();
      send_request(MODE_FIND, 0, 32'h0000_0005);
      send_request(MODE_DELETE, 0, 32'h0000_0005);
      send_request(MODE_INSERT, 1, 32'h0000_0001);
      send_request(MODE_INSERT, 31, 32'h0000_0001);
      send_request(MODE_INSERT, 0, 32'h8000_0000);
      send_request(MODE_INSERT, 1, 32'h7fff_ffff);
      send_request(MODE_INSERT, 1, 32'h0000_0000);
      send_request(MODE_INSERT, 0, 32'hffff_ffff);
      // duplicate at the tail; find and delete must hit the earlier copy
      send_request(MODE_INSERT, 4, 32'h0000_0000);
      send_request(MODE_FIND, 0, 32'h0000_0000);
      send_request(MODE_FIND, 0, 32'h7fff_ffff);
      send_request(MODE_DELETE, 7, 32'h0000_0000);
      send_request(MODE_DELETE, 0, 32'h8000_0000);
      send_request(MODE_NOP, 9, 32'h1234_5678);
      // capacity below the count: full, and full wins over a bad position
      write_capacity(2);
      send_request(MODE_INSERT, 30, 32'h0000_0005);
      send_request(MODE_FIND, 0, 32'hffff_ffff);
      write_capacity(0);
      send_request(MODE_INSERT, 0, 32'h0000_0005);
      write_capacity(31);
      send_request(MODE_INSERT, 3, 32'h0000_0005);
      send_request(MODE_DELETE, 0, 32'h0000_0005);
      send_request(MODE_FIND, 0, 32'h0000_0005);
   endtask

   // response side: random stalls, with one long stretch always ready
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         book.check_response(rsp_bus.status, rsp_bus.index, rsp_bus.count);
      sink_cycles = sink_cycles + 1;
      rsp_bus.ready <= (sink_cycles > 2500 && sink_cycles < 3700) ||
                       ($urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stalled <= 0;
      end else if (stalled >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $time, stalled);
         $display("ordered_array_list verification failed");
         $finish;
      end else begin
         stalled <= stalled + 1;
      end
   end

   initial begin
      book = new();
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= MODE_NOP;
      req_bus.position <= '0;
      req_bus.value    <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();

      for (int p = 0; p < PHASES; p++) begin
         write_capacity(CAP_W'(phase_cap[p]));
         refresh_pool();
         sender_calm = (p == 3);
         for (int k = 0; k < phase_len[p]; k++) begin
            if (p == 4 && k == 100) begin
               // hold the sender until every answer is back
               req_bus.valid <= 1'b0;
               wait_drained();
            end
            // alternate growing and shrinking runs so the list fills and empties
            random_item(((k / 30) % 2 == 0) ? 65 : 28);
         end
      end
      req_bus.valid <= 1'b0;
      wait_drained();

      $display("covered %0d requests: %0d insert, %0d delete, %0d find, %0d no-op; %s",
               book.noted, book.mode_seen[MODE_INSERT], book.mode_seen[MODE_DELETE],
               book.mode_seen[MODE_FIND], book.mode_seen[MODE_NOP],
               $sformatf("%0d capacity writes", cap_writes));
      $display("outcomes: %0d ok, %0d full, %0d bad position, %0d not found; %0d mismatches",
               book.status_seen[STAT_OK], book.status_seen[STAT_FULL],
               book.status_seen[STAT_POSITION], book.status_seen[STAT_MISS], book.failures);
      if (book.failures == 0 && book.awaited.size() == 0)
         $display("ordered_array_list verification clean");
      else
         $display("ordered_array_list verification failed");
      $finish;
   end

endmodule
